[hdl/lecp_pkg.sv]
package lecp_pkg;

    // Angle accumulator: units of 2^-20 degree
    localparam int ZFRAC        = 20;
    localparam int Z_W          = 30;
    localparam int CORDIC_STEPS = 24;

    // Vector prescale before the rotation steps, and headroom for the gain
    localparam int PRESCALE  = 24;
    localparam int XY_GROWTH = 2;

    typedef logic signed [Z_W-1:0] angle_acc_t;

    // atan(2^-i) in 2^-20 degree, rounded to nearest
    localparam angle_acc_t ATAN_UNITS [CORDIC_STEPS] = '{
        angle_acc_t'(47185920), angle_acc_t'(27855475), angle_acc_t'(14718068),
        angle_acc_t'(7471121),  angle_acc_t'(3750058),  angle_acc_t'(1876857),
        angle_acc_t'(938658),   angle_acc_t'(469357),   angle_acc_t'(234682),
        angle_acc_t'(117342),   angle_acc_t'(58671),    angle_acc_t'(29335),
        angle_acc_t'(14668),    angle_acc_t'(7334),     angle_acc_t'(3667),
        angle_acc_t'(1833),     angle_acc_t'(917),      angle_acc_t'(458),
        angle_acc_t'(229),      angle_acc_t'(115),      angle_acc_t'(57),
        angle_acc_t'(29),       angle_acc_t'(14),       angle_acc_t'(7)
    };

    localparam angle_acc_t QUARTER_TURN = angle_acc_t'(90 * 2**ZFRAC);

    // Where the final angle comes from
    typedef enum logic [2:0] {
        ANG_CORDIC,
        ANG_ZERO,
        ANG_HALF_TURN,
        ANG_UP,
        ANG_DOWN
    } angle_sel_t;

    typedef struct packed {
        logic       degenerate;
        angle_sel_t angle_sel;
    } seg_flags_t;

endpackage

[hdl/lecp_seg_if.sv]
interface lecp_seg_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (
        output valid, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

[hdl/lecp_polar_if.sv]
interface lecp_polar_if #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 8
);
    logic                              valid;
    logic                              ready;
    logic                              degenerate;
    logic signed [COORD_WIDTH+1:0]     left_x;
    logic signed [COORD_WIDTH-1:0]     middle_y;
    logic signed [COORD_WIDTH+1:0]     right_x;
    logic        [COORD_WIDTH:0]       segment_length;
    logic signed [ANGLE_FRAC_BITS+8:0] angle_degrees;

    modport source (
        output valid, degenerate, left_x, middle_y, right_x, segment_length,
               angle_degrees,
        input  ready
    );

    modport sink (
        input  valid, degenerate, left_x, middle_y, right_x, segment_length,
               angle_degrees,
        output ready
    );
endinterface

[hdl/lecp_front.sv]
module lecp_front #(
    parameter int CW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] start_x,
    input  logic signed [CW-1:0] start_y,
    input  logic signed [CW-1:0] end_x,
    input  logic signed [CW-1:0] end_y,
    output logic                 out_valid,
    output logic [2*CW+1:0]      out_rad,
    output logic [3*(CW+1)+CW+lecp_pkg::Z_W+$bits(lecp_pkg::seg_flags_t)-1:0] out_rest
);

    localparam int RAD_W  = 2 * CW + 2;
    localparam int REST_W = 3 * (CW + 1) + CW + lecp_pkg::Z_W + $bits(lecp_pkg::seg_flags_t);

    logic signed [CW:0]   dx, dy, neg_dx, neg_dy, sum_x, sum_y, sum_y_adj, cx, cy;
    logic [CW-1:0]        ax, ay;
    logic signed [CW-1:0] mid_y;
    lecp_pkg::angle_acc_t z0;
    lecp_pkg::seg_flags_t flags;
    logic [REST_W-1:0]    rest_a;

    logic                 vld_a_reg, vld_b_reg, vld_c_reg;
    logic [CW-1:0]        ax_reg, ay_reg;
    logic [2*CW-1:0]      sq_x_reg, sq_y_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [REST_W-1:0]    rest_a_reg, rest_b_reg, rest_c_reg;

    // Differences, sums, magnitudes and the half-plane fold
    always_comb
    begin
        dx        = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
        dy        = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
        neg_dx    = -dx;
        neg_dy    = -dy;
        sum_x     = {start_x[CW-1], start_x} + {end_x[CW-1], end_x};
        sum_y     = {start_y[CW-1], start_y} + {end_y[CW-1], end_y};
        sum_y_adj = sum_y + {{CW{1'b0}}, sum_y[CW]};
        mid_y     = sum_y_adj[CW:1];
        ax        = dx[CW] ? neg_dx[CW-1:0] : dx[CW-1:0];
        ay        = dy[CW] ? neg_dy[CW-1:0] : dy[CW-1:0];

        flags.degenerate = (dx == '0) && (dy == '0);
        if (dy == '0)
        begin
            flags.angle_sel = dx[CW] ? lecp_pkg::ANG_HALF_TURN : lecp_pkg::ANG_ZERO;
        end
        else if (dx == '0)
        begin
            flags.angle_sel = dy[CW] ? lecp_pkg::ANG_DOWN : lecp_pkg::ANG_UP;
        end
        else
        begin
            flags.angle_sel = lecp_pkg::ANG_CORDIC;
        end

        if (dx[CW] && !dy[CW])
        begin
            cx = dy;
            cy = neg_dx;
            z0 = lecp_pkg::QUARTER_TURN;
        end
        else if (dx[CW])
        begin
            cx = neg_dy;
            cy = dx;
            z0 = -lecp_pkg::QUARTER_TURN;
        end
        else
        begin
            cx = dx;
            cy = dy;
            z0 = '0;
        end

        rest_a = {cx, cy, z0, sum_x, mid_y, flags};
    end

    // Valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    // Stage A: operands; stage B: squares; stage C: radicand
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg     <= ax;
            ay_reg     <= ay;
            rest_a_reg <= rest_a;
            sq_x_reg   <= ax_reg * ax_reg;
            sq_y_reg   <= ay_reg * ay_reg;
            rest_b_reg <= rest_a_reg;
            rad_reg    <= RAD_W'(sq_x_reg) + RAD_W'(sq_y_reg);
            rest_c_reg <= rest_b_reg;
        end
    end

    assign out_valid = vld_c_reg;
    assign out_rad   = rad_reg;
    assign out_rest  = rest_c_reg;

endmodule

[hdl/lecp_isqrt.sv]
module lecp_isqrt #(
    parameter int N      = 17,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [2*N-1:0]    in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [N-1:0]      out_root,
    output logic              out_exact,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [N];
    logic [N+1:0]      rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [2*N-1:0]    rad_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    // One root bit per stage, most significant first
    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam int B = N - 1 - k;

        logic              vld_in;
        logic [N+1:0]      rem_in, rem_sh, trial, rem_next;
        logic [N-1:0]      root_in, root_next;
        logic [2*N-1:0]    rad_in;
        logic [SIDE_W-1:0] side_in;
        logic              fits;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end
        else
        begin : g_chain
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit
        always_comb
        begin
            rem_sh    = {rem_in[N-1:0], rad_in[2*B+1 -: 2]};
            trial     = {root_in, 2'b01};
            fits      = (rem_sh >= trial);
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[N-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_exact = (rem_reg[N-1] == '0);
    assign out_side  = side_reg[N-1];

endmodule

[hdl/lecp_cordic.sv]
module lecp_cordic #(
    parameter int XY_W   = 43,
    parameter int SIDE_W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] in_x,
    input  logic signed [XY_W-1:0] in_y,
    input  lecp_pkg::angle_acc_t   in_z,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output lecp_pkg::angle_acc_t   out_z,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int STEPS = lecp_pkg::CORDIC_STEPS;

    logic                   vld_reg  [STEPS];
    logic signed [XY_W-1:0] x_reg    [STEPS];
    logic signed [XY_W-1:0] y_reg    [STEPS];
    lecp_pkg::angle_acc_t   z_reg    [STEPS];
    logic [SIDE_W-1:0]      side_reg [STEPS];

    // One micro-rotation per stage, driving y toward zero
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic                   vld_in;
        logic signed [XY_W-1:0] x_in, y_in, x_sh, y_sh, x_next, y_next;
        lecp_pkg::angle_acc_t   z_in, z_next;
        logic [SIDE_W-1:0]      side_in;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign x_in    = in_x;
            assign y_in    = in_y;
            assign z_in    = in_z;
            assign side_in = in_side;
        end
        else
        begin : g_chain
            assign vld_in  = vld_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign y_in    = y_reg[k-1];
            assign z_in    = z_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            x_sh = x_in >>> k;
            y_sh = y_in >>> k;
            if (!y_in[XY_W-1] && (y_in != '0))
            begin
                x_next = x_in + y_sh;
                y_next = y_in - x_sh;
                z_next = z_in + lecp_pkg::ATAN_UNITS[k];
            end
            else
            begin
                x_next = x_in - y_sh;
                y_next = y_in + x_sh;
                z_next = z_in - lecp_pkg::ATAN_UNITS[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_z     = z_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

[hdl/line_endpoints_to_centered_polar.sv]
// Pipeline stages from an accepted word to its result:
//   3 front stages, COORD_WIDTH + 1 square-root stages, 24 CORDIC stages, 1 output stage.
// Throughput: one word per cycle; the square-root and CORDIC chains each retire one
//   word per clock, and the whole pipeline holds as one while the output word waits.
// Reset (rst_n, asynchronous, active low) clears the valid bits only; no word is
//   in flight afterwards and the block accepts input at once.
module line_endpoints_to_centered_polar #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    lecp_seg_if.sink            seg,
    lecp_polar_if.source        polar
);

    localparam int N       = COORD_WIDTH + 1;
    localparam int LW      = COORD_WIDTH + 3;
    localparam int OX_W    = COORD_WIDTH + 2;
    localparam int ANG_W   = ANGLE_FRAC_BITS + 9;
    localparam int Z_W     = lecp_pkg::Z_W;
    localparam int FLAG_W  = $bits(lecp_pkg::seg_flags_t);
    localparam int XY_W    = COORD_WIDTH + 1 + lecp_pkg::PRESCALE + lecp_pkg::XY_GROWTH;
    localparam int SH      = lecp_pkg::ZFRAC - ANGLE_FRAC_BITS;
    localparam int SIDE1_W = 3 * N + COORD_WIDTH + Z_W + FLAG_W;
    localparam int SIDE2_W = N + 1 + N + COORD_WIDTH + FLAG_W;

    localparam lecp_pkg::angle_acc_t Z_HALF  = lecp_pkg::angle_acc_t'(2**(SH-1));
    localparam lecp_pkg::angle_acc_t Z_LIM   = lecp_pkg::angle_acc_t'(180 * 2**ANGLE_FRAC_BITS);
    localparam lecp_pkg::angle_acc_t Z_RIGHT = lecp_pkg::angle_acc_t'(90 * 2**ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(Z_LIM);
    localparam logic signed [ANG_W-1:0] ANG_MIN = -ANG_MAX;

    logic advance;

    // Front to square root
    logic                 fr_valid;
    logic [2*N-1:0]       fr_rad;
    logic [SIDE1_W-1:0]   fr_rest;

    // Square root to CORDIC
    logic                 sq_valid;
    logic [N-1:0]         sq_root;
    logic                 sq_exact;
    logic [SIDE1_W-1:0]   sq_side;
    logic signed [N-1:0]  sq_cx, sq_cy, sq_sum_x;
    lecp_pkg::angle_acc_t sq_z0;
    logic signed [COORD_WIDTH-1:0] sq_mid_y;
    lecp_pkg::seg_flags_t sq_flags;
    logic signed [XY_W-1:0] cx_w, cy_w;
    logic [SIDE2_W-1:0]   cd_side_in;

    // CORDIC to output stage
    logic                 cd_valid;
    lecp_pkg::angle_acc_t cd_z;
    logic [SIDE2_W-1:0]   cd_side;
    logic [N-1:0]         fin_root;
    logic                 fin_exact;
    logic signed [N-1:0]  fin_sum_x;
    logic signed [COORD_WIDTH-1:0] fin_mid_y;
    lecp_pkg::seg_flags_t fin_flags;

    // Output stage arithmetic
    logic signed [LW-1:0] m_w, s_w, diff_w, diff_adj, neg_w, t_w;
    logic signed [LW-1:0] neg_half, ex_half, inex_half, left_w, lm_w, right_w;
    lecp_pkg::angle_acc_t z_sum, z_rnd, z_clamp, z_pick;

    // Output register
    logic                          out_vld_reg;
    logic                          degenerate_reg;
    logic signed [OX_W-1:0]        left_x_reg, right_x_reg;
    logic signed [COORD_WIDTH-1:0] middle_y_reg;
    logic [N-1:0]                  length_reg;
    logic signed [ANG_W-1:0]       angle_reg;

    // Whole pipeline moves unless the output word is held
    assign advance   = !out_vld_reg || polar.ready;
    assign seg.ready = advance;

    lecp_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (seg.valid),
        .start_x   (seg.start_x),
        .start_y   (seg.start_y),
        .end_x     (seg.end_x),
        .end_y     (seg.end_y),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_rest  (fr_rest)
    );

    lecp_isqrt #(
        .N      (N),
        .SIDE_W (SIDE1_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_side   (fr_rest),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_exact (sq_exact),
        .out_side  (sq_side)
    );

    // Scale the folded vector and repack what rides along
    assign {sq_cx, sq_cy, sq_z0, sq_sum_x, sq_mid_y, sq_flags} = sq_side;
    assign cx_w       = XY_W'(sq_cx) <<< lecp_pkg::PRESCALE;
    assign cy_w       = XY_W'(sq_cy) <<< lecp_pkg::PRESCALE;
    assign cd_side_in = {sq_root, sq_exact, sq_sum_x, sq_mid_y, sq_flags};

    lecp_cordic #(
        .XY_W   (XY_W),
        .SIDE_W (SIDE2_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sq_valid),
        .in_x      (cx_w),
        .in_y      (cy_w),
        .in_z      (sq_z0),
        .in_side   (cd_side_in),
        .out_valid (cd_valid),
        .out_z     (cd_z),
        .out_side  (cd_side)
    );

    assign {fin_root, fin_exact, fin_sum_x, fin_mid_y, fin_flags} = cd_side;

    // Centered segment ends, halved toward zero
    always_comb
    begin
        m_w       = LW'(fin_root);
        s_w       = LW'(fin_sum_x);
        diff_w    = s_w - m_w;
        diff_adj  = diff_w + {{(LW-1){1'b0}}, diff_w[LW-1]};
        ex_half   = diff_adj >>> 1;
        t_w       = diff_w - LW'(1);
        neg_w     = m_w - s_w;
        neg_half  = neg_w >>> 1;
        inex_half = t_w[LW-1] ? -neg_half : (t_w >>> 1);
        left_w    = fin_exact ? ex_half : inex_half;
        lm_w      = left_w + m_w;
        right_w   = (fin_exact || !lm_w[LW-1]) ? lm_w : (lm_w + LW'(1));
    end

    // Round the angle to the output grid and clamp to a half turn
    always_comb
    begin
        z_sum = cd_z + Z_HALF;
        z_rnd = z_sum >>> SH;
        if (z_rnd > Z_LIM)
        begin
            z_clamp = Z_LIM;
        end
        else if (z_rnd < -Z_LIM)
        begin
            z_clamp = -Z_LIM;
        end
        else
        begin
            z_clamp = z_rnd;
        end

        case (fin_flags.angle_sel)
            lecp_pkg::ANG_CORDIC:    z_pick = z_clamp;
            lecp_pkg::ANG_ZERO:      z_pick = '0;
            lecp_pkg::ANG_HALF_TURN: z_pick = Z_LIM;
            lecp_pkg::ANG_UP:        z_pick = Z_RIGHT;
            lecp_pkg::ANG_DOWN:      z_pick = -Z_RIGHT;
            default:                 z_pick = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= cd_valid;
        end
    end

    // Load the output word; zero every value field for coinciding endpoints
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            degenerate_reg <= fin_flags.degenerate;
            if (fin_flags.degenerate)
            begin
                left_x_reg   <= '0;
                right_x_reg  <= '0;
                middle_y_reg <= '0;
                length_reg   <= '0;
                angle_reg    <= '0;
            end
            else
            begin
                left_x_reg   <= left_w[OX_W-1:0];
                right_x_reg  <= right_w[OX_W-1:0];
                middle_y_reg <= fin_mid_y;
                length_reg   <= fin_root;
                angle_reg    <= ANG_W'(z_pick);
            end
        end
    end

    assign polar.valid          = out_vld_reg;
    assign polar.degenerate     = degenerate_reg;
    assign polar.left_x         = left_x_reg;
    assign polar.middle_y       = middle_y_reg;
    assign polar.right_x        = right_x_reg;
    assign polar.segment_length = length_reg;
    assign polar.angle_degrees  = angle_reg;

    // Checks
    logic signed [LW-1:0] chk_span, chk_len;
    assign chk_span = LW'(polar.right_x) - LW'(polar.left_x);
    assign chk_len  = LW'(polar.segment_length);

    a_no_take_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (polar.valid && !polar.ready) |-> !seg.ready)
        else $error("input taken while output word held");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (polar.valid && polar.degenerate) |->
            (polar.left_x == '0 && polar.right_x == '0 && polar.middle_y == '0 &&
             polar.segment_length == '0 && polar.angle_degrees == '0))
        else $error("degenerate word carries nonzero fields");

    a_span_matches_length: assert property (@(posedge clk) disable iff (!rst_n)
        (polar.valid && !polar.degenerate) |->
            (chk_span == chk_len || chk_span == chk_len + LW'(1)))
        else $error("segment ends disagree with length");

    a_angle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        polar.valid |-> (polar.angle_degrees <= ANG_MAX && polar.angle_degrees >= ANG_MIN))
        else $error("angle beyond half turn");

endmodule
